[hw/rtl/hill_cipher_encrypt_assert.svh]
// ----------------------------------------------------------------------------
// Hill cipher encryptor assertion macros
// Shared property wrappers, clocked on i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef HILL_CIPHER_ENCRYPT_ASSERT_SVH
`define HILL_CIPHER_ENCRYPT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HCE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/hce_pkg.sv]
// ----------------------------------------------------------------------------
// Hill cipher encryptor package
// Shared constants, register indexes and block types.
// ----------------------------------------------------------------------------
package hce_pkg;

    localparam int MAX_N      = 6;
    localparam int LETTER_W   = 5;
    localparam int N_W        = 3;
    localparam int KEY_WORD_W = 60;
    localparam int KEY_ROW_W  = MAX_N * LETTER_W;
    localparam int KEY_ALL_W  = 3 * KEY_WORD_W;
    localparam int PROD_W     = 2 * LETTER_W;
    localparam int SUM_W      = 13;
    localparam int QUOT_W     = 8;

    localparam logic [LETTER_W-1:0] PAD_LETTER = 5'd23;
    localparam logic [6:0]          ASCII_A_LC = 7'd97;
    localparam logic [5:0]          ALPHA      = 6'd26;
    // floor(2^16 / 26) rounded down; quotient is exact or one low.
    localparam logic [11:0]         RECIP_26   = 12'd2520;

    // Configuration register indexes.
    localparam logic [1:0] CFG_KEY_SIZE = 2'd0;
    localparam logic [1:0] CFG_KEY_W0   = 2'd1;
    localparam logic [1:0] CFG_KEY_W1   = 2'd2;
    localparam logic [1:0] CFG_KEY_W2   = 2'd3;

    // One complete plaintext block handed from front to back.
    typedef struct packed {
        logic [MAX_N-1:0][LETTER_W-1:0] letters;
        logic [N_W-1:0]                 n;
        logic                           done;
    } t_block;

    // Configuration view seen by the front end.
    typedef struct packed {
        logic [N_W-1:0] n;
        logic           clr;
    } t_cfg_view;

endpackage

[hw/rtl/hce_front.sv]
// ----------------------------------------------------------------------------
// Hill cipher front end
// Classifies input bytes, collects letters and pushes full or padded blocks.
// ----------------------------------------------------------------------------
module hce_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hce_pkg::t_cfg_view  i_cfg,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [7:0]          i_s_tdata,
    input  logic                i_s_tlast,
    input  logic                i_q_full,
    output logic                o_q_push,
    output hce_pkg::t_block     o_q_data
);
    import hce_pkg::*;

    logic [MAX_N-1:0][LETTER_W-1:0] r_buf;
    logic [N_W-1:0]                 r_fill;
    logic [N_W-1:0]                 n_fill;
    logic [N_W-1:0]                 eff_fill;
    logic [N_W-1:0]                 cnt_after;
    logic [LETTER_W-1:0]            letter;
    logic                           is_upper;
    logic                           is_lower;
    logic                           has_letter;
    logic                           accept;
    logic                           full_blk;
    logic                           flush;

    assign o_s_tready = !i_q_full;
    assign accept     = i_s_tvalid && o_s_tready;

    // Letter classification and case folding.
    always_comb begin
        is_upper   = (i_s_tdata >= 8'd65) && (i_s_tdata <= 8'd90);
        is_lower   = (i_s_tdata >= 8'd97) && (i_s_tdata <= 8'd122);
        has_letter = is_upper || is_lower;
        if (is_upper) begin
            letter = LETTER_W'(i_s_tdata - 8'd65);
        end else begin
            letter = LETTER_W'(i_s_tdata - 8'd97);
        end
    end

    // Block completion and end-of-message flush.
    always_comb begin
        eff_fill  = (r_fill >= i_cfg.n) ? '0 : r_fill;
        cnt_after = eff_fill + N_W'(has_letter);
        full_blk  = has_letter && (cnt_after >= i_cfg.n);
        flush     = i_s_tlast && (cnt_after != '0) && !full_blk;
        o_q_push  = accept && (full_blk || flush);
    end

    // Block payload: held letters, the new letter, then padding.
    always_comb begin
        for (int k = 0; k < MAX_N; k++) begin
            if (N_W'(k) >= i_cfg.n) begin
                o_q_data.letters[k] = '0;
            end else if (has_letter && (N_W'(k) == eff_fill)) begin
                o_q_data.letters[k] = letter;
            end else if (N_W'(k) < eff_fill) begin
                o_q_data.letters[k] = r_buf[k];
            end else begin
                o_q_data.letters[k] = PAD_LETTER;
            end
        end
        o_q_data.n    = i_cfg.n;
        o_q_data.done = i_s_tlast;
    end

    // Fill count update.
    always_comb begin
        n_fill = r_fill;
        if (i_cfg.clr) begin
            n_fill = '0;
        end else if (accept) begin
            n_fill = (full_blk || flush) ? '0 : cnt_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // Letter store, written at the current fill position.
    always_ff @(posedge i_clk) begin
        if (accept && has_letter) begin
            r_buf[eff_fill] <= letter;
        end
    end

endmodule

[hw/rtl/hce_queue.sv]
// ----------------------------------------------------------------------------
// Hill cipher block queue
// Two-entry queue of plaintext blocks between front and back ends.
// ----------------------------------------------------------------------------
module hce_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hce_pkg::t_block i_push_data,
    output logic            o_full,
    input  logic            i_pop,
    output hce_pkg::t_block o_pop_data,
    output logic            o_empty
);
    import hce_pkg::*;

    t_block      r_mem [2];
    logic        r_wr;
    logic        r_rd;
    logic [1:0]  r_cnt;

    assign o_full     = (r_cnt == 2'd2);
    assign o_empty    = (r_cnt == 2'd0);
    assign o_pop_data = r_mem[r_rd];

    // Pointer and occupancy tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

[hw/rtl/hce_back.sv]
// ----------------------------------------------------------------------------
// Hill cipher back end
// Key matrix times queued blocks: one cipher letter a cycle unless stalled.
// ----------------------------------------------------------------------------
`include "hill_cipher_encrypt_assert.svh"

module hce_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [hce_pkg::KEY_ALL_W-1:0]  i_key_all,
    input  logic                           i_q_empty,
    input  hce_pkg::t_block                i_q_data,
    output logic                           o_q_pop,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [7:0]                     o_m_tdata,
    output logic                           o_m_tlast,
    output logic                           o_m_tuser
);
    import hce_pkg::*;

    logic                            en;
    logic                            issue;
    logic                            row_last;
    logic [N_W-1:0]                  r_row;
    logic [KEY_ROW_W-1:0]            key_row;

    logic                            r_a_vld;
    logic [MAX_N-1:0][PROD_W-1:0]    r_a_prod;
    logic                            r_a_last;
    logic                            r_a_done;

    logic                            r_b_vld;
    logic [SUM_W-1:0]                r_b_sum;
    logic [SUM_W-1:0]                n_b_sum;
    logic                            r_b_last;
    logic                            r_b_done;

    logic                            r_c_vld;
    logic [SUM_W-1:0]                r_c_sum;
    logic [QUOT_W-1:0]               r_c_quot;
    logic [SUM_W+11:0]               quot_prod;
    logic                            r_c_last;
    logic                            r_c_done;

    logic [SUM_W-1:0]                rem_wide;
    logic [5:0]                      rem;
    logic [LETTER_W-1:0]             rem_fix;

    logic                            r_out_vld;
    logic [6:0]                      r_out_byte;
    logic                            r_out_last;
    logic                            r_out_done;

    // Whole pipeline advances when the output register can take a letter.
    assign en       = !r_out_vld || i_m_tready;
    assign issue    = en && !i_q_empty;
    assign row_last = (r_row == i_q_data.n - N_W'(1));
    assign o_q_pop  = issue && row_last;

    // Key row for the letter being issued.
    always_comb begin
        case (r_row)
            3'd0:    key_row = i_key_all[0*KEY_ROW_W +: KEY_ROW_W];
            3'd1:    key_row = i_key_all[1*KEY_ROW_W +: KEY_ROW_W];
            3'd2:    key_row = i_key_all[2*KEY_ROW_W +: KEY_ROW_W];
            3'd3:    key_row = i_key_all[3*KEY_ROW_W +: KEY_ROW_W];
            3'd4:    key_row = i_key_all[4*KEY_ROW_W +: KEY_ROW_W];
            3'd5:    key_row = i_key_all[5*KEY_ROW_W +: KEY_ROW_W];
            default: key_row = '0;
        endcase
    end

    // Row sequencer within the head block.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else if (issue) begin
            r_row <= row_last ? '0 : r_row + N_W'(1);
        end
    end

    // Stage A: one product per column; unused columns carry zero letters.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < MAX_N; k++) begin
                r_a_prod[k] <= PROD_W'(key_row[k*LETTER_W +: LETTER_W]) *
                               PROD_W'(i_q_data.letters[k]);
            end
            r_a_last <= row_last;
            r_a_done <= row_last && i_q_data.done;
        end
    end

    // Stage B: sum of the products.
    always_comb begin
        n_b_sum = '0;
        for (int k = 0; k < MAX_N; k++) begin
            n_b_sum = n_b_sum + SUM_W'(r_a_prod[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_sum  <= n_b_sum;
            r_b_last <= r_a_last;
            r_b_done <= r_a_done;
        end
    end

    // Stage C: quotient estimate by reciprocal multiplication.
    assign quot_prod = (SUM_W+12)'(r_b_sum) * (SUM_W+12)'(RECIP_26);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_sum  <= r_b_sum;
            r_c_quot <= quot_prod[16 +: QUOT_W];
            r_c_last <= r_b_last;
            r_c_done <= r_b_done;
        end
    end

    // Remainder with a single correction step, then ASCII offset.
    always_comb begin
        rem_wide = r_c_sum - SUM_W'(r_c_quot) * SUM_W'(ALPHA);
        rem      = rem_wide[5:0];
        if (rem >= ALPHA) begin
            rem_fix = LETTER_W'(rem - ALPHA);
        end else begin
            rem_fix = LETTER_W'(rem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_byte <= ASCII_A_LC + 7'(rem_fix);
            r_out_last <= r_c_last;
            r_out_done <= r_c_done;
        end
    end

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_a_vld   <= issue;
            r_b_vld   <= r_a_vld;
            r_c_vld   <= r_b_vld;
            r_out_vld <= r_c_vld;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {1'b0, r_out_byte};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_done;

    `HCE_ASSERT_SAME(a_row_in_block, !i_q_empty, r_row < i_q_data.n, "row beyond block")
    `HCE_ASSERT_NEXT(a_row_wraps, o_q_pop, r_row == '0, "row did not wrap after block")
    `HCE_ASSERT_SAME(a_letter_range, o_m_tvalid,
        (o_m_tdata >= 8'd97) && (o_m_tdata <= 8'd122), "cipher letter out of range")
    `HCE_ASSERT_SAME(a_done_on_last, o_m_tvalid && o_m_tuser, o_m_tlast,
        "message end not on block end")

endmodule

[hw/rtl/hill_cipher_encrypt.sv]
// ----------------------------------------------------------------------------
// Hill cipher encryptor, top level
// Letter stream in, Hill cipher ciphertext letters out, key set by writes.
// ----------------------------------------------------------------------------
// Channel   Direction  Content
// s_*       in         tdata[7:0] byte, tlast end of message
// m_*       out        tdata[6:0] letter (bit 7 zero), tlast block end,
//                      tuser message end
// cfg_*     in         idx 0 key size, 1..3 key words, data 60 bits
//
// The front end takes one byte per cycle; a finished block goes into a
// two-entry queue, and the input stalls only while that queue is full.
// The back end drains a block of n letters, one letter per cycle while
// the output is not stalled, through a four-register multiply, sum and
// modulo pipeline (stages A, B, C, output), fed from the queue entry.
// Reset is synchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module hill_cipher_encrypt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [1:0]  i_cfg_idx,
    input  logic [59:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // in_byte [7:0]
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // cipher_byte [6:0], zero [7]
    output logic        o_m_tlast,
    output logic        o_m_tuser    // message_done [0]
);
    import hce_pkg::*;

    logic [N_W-1:0]        r_key_size;
    logic [KEY_WORD_W-1:0] r_key_w0;
    logic [KEY_WORD_W-1:0] r_key_w1;
    logic [KEY_WORD_W-1:0] r_key_w2;
    t_cfg_view             cfg_view;
    t_block                push_data;
    t_block                pop_data;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_full;
    logic                  q_empty;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_size <= N_W'(1);
            r_key_w0   <= '0;
            r_key_w1   <= '0;
            r_key_w2   <= '0;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                CFG_KEY_SIZE: r_key_size <= i_cfg_data[N_W-1:0];
                CFG_KEY_W0:   r_key_w0   <= i_cfg_data;
                CFG_KEY_W1:   r_key_w1   <= i_cfg_data;
                CFG_KEY_W2:   r_key_w2   <= i_cfg_data;
                default:      r_key_w0   <= r_key_w0;
            endcase
        end
    end

    // Block length clamped to 1..MAX_N; a key size write drops a partial block.
    always_comb begin
        if (r_key_size == '0) begin
            cfg_view.n = N_W'(1);
        end else if (r_key_size > N_W'(MAX_N)) begin
            cfg_view.n = N_W'(MAX_N);
        end else begin
            cfg_view.n = r_key_size;
        end
        cfg_view.clr = i_cfg_wen && (i_cfg_idx == CFG_KEY_SIZE);
    end

    hce_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg_view),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (push_data)
    );

    hce_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_pop_data  (pop_data),
        .o_empty     (q_empty)
    );

    hce_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key_all  ({r_key_w2, r_key_w1, r_key_w0}),
        .i_q_empty  (q_empty),
        .i_q_data   (pop_data),
        .o_q_pop    (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
